/* rtl/rva_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Axis-angle rotation package
// Shared types, fixed-point constants and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package rva_pkg;

  localparam int unsigned TrigSteps = 24;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 32;
  localparam int unsigned QueueDepth = 4;

  localparam logic signed [33:0] PiQ28      = 34'sd843314857;
  localparam logic signed [33:0] TwoPiQ28   = 34'sd1686629713;
  localparam logic signed [33:0] HalfPiQ28  = 34'sd421657428;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [34:0] OneQ30     = 35'sd1073741824;

  typedef logic signed [31:0] word_t;

  typedef struct packed {
    word_t [2:0]       vec;
    logic              zero;
    logic [2:0]        neg;
    logic [2:0][31:0]  mag;
    logic              flip;
    logic signed [33:0] z;
  } rva_item_t;

  typedef struct packed {
    word_t [2:0] rot;
    logic        zero_axis;
    logic        saturated;
  } rva_result_t;

  function automatic logic signed [33:0] atan_q30(input int unsigned k);
    logic signed [33:0] r;
    case (k)
      0:  r = 34'sd843314856;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043836;
      3:  r = 34'sd133525158;
      4:  r = 34'sd67021686;
      5:  r = 34'sd33543515;
      6:  r = 34'sd16775850;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194282;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      23: r = 34'sd127;
      24: r = 34'sd63;
      25: r = 34'sd31;
      26: r = 34'sd15;
      27: r = 34'sd8;
      28: r = 34'sd4;
      29: r = 34'sd2;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/rva_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Axis-angle rotation front end
// Takes words, detects a zero axis, scales the axis and reduces the angle.
// ---------------------------------------------------------------------------
module rva_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic signed [31:0] axis_x_i,
  input  logic signed [31:0] axis_y_i,
  input  logic signed [31:0] axis_z_i,
  input  logic signed [31:0] angle_i,
  output logic              item_valid_o,
  output rva_pkg::rva_item_t item_o,
  input  logic              q_full_i
);
  import rva_pkg::*;

  logic f_adv;

  logic               f1_valid_q;
  word_t [2:0]        f1_vec_q;
  logic [2:0]         f1_neg_q;
  logic [2:0][31:0]   f1_mag_q;
  logic               f1_zero_q;
  logic signed [33:0] f1_ang_q;

  logic [2:0]         f1_neg_d;
  logic [2:0][31:0]   f1_mag_d;
  logic signed [33:0] f1_ang_d;
  word_t [2:0]        ax;

  logic      f2_valid_q;
  rva_item_t f2_item_q;
  rva_item_t f2_item_d;

  logic [31:0]        maxm;
  logic [4:0]         hi;
  logic [4:0]         sh;
  logic signed [33:0] a2;

  assign f_adv = ~f2_valid_q | ~q_full_i;
  assign full  = ~f_adv;

  always_comb begin
    ax = {axis_z_i, axis_y_i, axis_x_i};
    for (int i = 0; i < 3; i++) begin
      f1_neg_d[i] = ax[i][31];
      f1_mag_d[i] = ax[i][31] ? (~ax[i] + 32'd1) : ax[i];
    end
    f1_ang_d = {{2{angle_i[31]}}, angle_i};
    if (f1_ang_d >= PiQ28) begin
      f1_ang_d = f1_ang_d - TwoPiQ28;
    end else if (f1_ang_d < -PiQ28) begin
      f1_ang_d = f1_ang_d + TwoPiQ28;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else if (f_adv) begin
      f1_valid_q <= push;
      f2_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_adv) begin
      f1_vec_q  <= {vec_z_i, vec_y_i, vec_x_i};
      f1_neg_q  <= f1_neg_d;
      f1_mag_q  <= f1_mag_d;
      f1_zero_q <= (axis_x_i == 32'sd0) && (axis_y_i == 32'sd0) && (axis_z_i == 32'sd0);
      f1_ang_q  <= f1_ang_d;
      f2_item_q <= f2_item_d;
    end
  end

  always_comb begin
    maxm = f1_mag_q[0];
    if (f1_mag_q[1] > maxm) maxm = f1_mag_q[1];
    if (f1_mag_q[2] > maxm) maxm = f1_mag_q[2];
    hi = 5'd0;
    for (int b = 0; b < 32; b++) begin
      if (maxm[b]) hi = 5'(b);
    end
    sh = (hi >= 5'd30) ? 5'd0 : 5'(5'd30 - hi);

    a2 = f1_ang_q;
    if (a2 >= PiQ28) begin
      a2 = a2 - TwoPiQ28;
    end else if (a2 < -PiQ28) begin
      a2 = a2 + TwoPiQ28;
    end
    f2_item_d.flip = 1'b0;
    if (a2 > HalfPiQ28) begin
      a2 = a2 - PiQ28;
      f2_item_d.flip = 1'b1;
    end else if (a2 < -HalfPiQ28) begin
      a2 = a2 + PiQ28;
      f2_item_d.flip = 1'b1;
    end
    f2_item_d.z    = a2 <<< 2;
    f2_item_d.vec  = f1_vec_q;
    f2_item_d.zero = f1_zero_q;
    f2_item_d.neg  = f1_neg_q;
    for (int i = 0; i < 3; i++) begin
      f2_item_d.mag[i] = f1_mag_q[i] << sh;
    end
  end

  assign item_valid_o = f2_valid_q;
  assign item_o       = f2_item_q;

endmodule
`default_nettype wire

/* rtl/rva_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Axis-angle rotation item queue
// Small FIFO that decouples the front end from the arithmetic back end.
// ---------------------------------------------------------------------------
module rva_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  rva_pkg::rva_item_t data_i,
  input  logic               pop_i,
  output logic               empty_o,
  output rva_pkg::rva_item_t data_o
);
  import rva_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  rva_item_t       mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q;
  logic [PtrW-1:0] rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wr_q <= wr_q + 1'b1;
      if (pop_i && !empty_o) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push_i && !full_o) - (PtrW+1)'(pop_i && !empty_o);
    end
  end

endmodule
`default_nettype wire

/* rtl/rva_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Axis-angle rotation back end
// Pipelined norm, square root, division, CORDIC, matrix build and product.
// ---------------------------------------------------------------------------
module rva_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  rva_pkg::rva_item_t   q_data_i,
  output logic                 q_pop_o,
  output logic                 empty,
  input  logic                 pop,
  output rva_pkg::rva_result_t res_o
);
  import rva_pkg::*;

  function automatic int unsigned pair_idx(input int unsigned i, input int unsigned j);
    int unsigned r;
    if (i == j) r = i;
    else if (i + j == 1) r = 3;
    else if (i + j == 2) r = 4;
    else r = 5;
    return r;
  endfunction

  localparam logic signed [39:0] AccMax = 40'sd2147483647;
  localparam logic signed [39:0] AccMin = -40'sd2147483648;

  logic adv;

  // Squares and their sum.
  logic             s0_valid_q;
  rva_item_t        s0_item_q;
  logic [2:0][63:0] s0_sq_q;
  logic             s1_valid_q;
  rva_item_t        s1_item_q;
  logic [63:0]      s1_sum_q;

  // Square root with the CORDIC alongside.
  logic               sq_valid_q [SqrtSteps];
  rva_item_t          sq_item_q  [SqrtSteps];
  logic [63:0]        sq_rad_q   [SqrtSteps];
  logic [33:0]        sq_rem_q   [SqrtSteps];
  logic [31:0]        sq_root_q  [SqrtSteps];
  logic signed [33:0] cx_q       [SqrtSteps];
  logic signed [33:0] cy_q       [SqrtSteps];
  logic signed [33:0] cz_q       [SqrtSteps];

  // Division of the scaled axis by its norm.
  logic               dv_valid_q [DivSteps];
  rva_item_t          dv_item_q  [DivSteps];
  logic [2:0][31:0]   dv_rem_q   [DivSteps];
  logic [2:0][31:0]   dv_low_q   [DivSteps];
  logic [2:0][31:0]   dv_quo_q   [DivSteps];
  logic [31:0]        dv_n_q     [DivSteps];
  logic signed [33:0] dv_c_q     [DivSteps];
  logic signed [33:0] dv_s_q     [DivSteps];

  // Matrix stages.
  logic               mu_valid_q;
  rva_item_t          mu_item_q;
  logic signed [32:0] mu_u_q [3];
  logic signed [33:0] mu_c_q;
  logic signed [33:0] mu_s_q;
  logic signed [34:0] mu_omc_q;

  logic               m0_valid_q;
  rva_item_t          m0_item_q;
  logic signed [65:0] m0_uu_q [6];
  logic signed [66:0] m0_su_q [3];
  logic signed [33:0] m0_c_q;
  logic signed [34:0] m0_omc_q;

  logic               m1_valid_q;
  rva_item_t          m1_item_q;
  logic signed [70:0] m1_p_q [6];
  logic signed [35:0] m1_t_q [3];
  logic signed [33:0] m1_c_q;

  logic               m2_valid_q;
  rva_item_t          m2_item_q;
  logic signed [35:0] m2_r_q [3][3];

  logic               m3_valid_q;
  rva_item_t          m3_item_q;
  logic signed [67:0] m3_pr_q [3][3];

  logic               m4_valid_q;
  rva_item_t          m4_item_q;
  logic signed [39:0] m4_acc_q [3];

  // Output buffer.
  rva_result_t ob_mem_q [2];
  logic        ob_wr_q;
  logic        ob_rd_q;
  logic [1:0]  ob_cnt_q;
  logic        ob_full;
  logic        ob_push;
  logic        ob_pop;
  rva_result_t ob_d;

  assign ob_full = (ob_cnt_q == 2'd2);
  assign adv     = ~m4_valid_q | ~ob_full;
  assign q_pop_o = adv & ~q_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s0_valid_q <= ~q_empty_i;
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_item_q <= q_data_i;
      for (int i = 0; i < 3; i++) begin
        s0_sq_q[i] <= 64'(q_data_i.mag[i]) * 64'(q_data_i.mag[i]);
      end
      s1_item_q <= s0_item_q;
      s1_sum_q  <= s0_sq_q[0] + s0_sq_q[1] + s0_sq_q[2];
    end
  end

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    logic               valid_in;
    rva_item_t          item_in;
    logic [63:0]        rad_in;
    logic [33:0]        rem_in;
    logic [31:0]        root_in;
    logic signed [33:0] x_in;
    logic signed [33:0] y_in;
    logic signed [33:0] z_in;
    logic [33:0]        rem_sh;
    logic [33:0]        trial;
    logic               ge;
    logic signed [33:0] x_d;
    logic signed [33:0] y_d;
    logic signed [33:0] z_d;

    if (k == 0) begin : g_first
      assign valid_in = s1_valid_q;
      assign item_in  = s1_item_q;
      assign rad_in   = s1_sum_q;
      assign rem_in   = '0;
      assign root_in  = '0;
      assign x_in     = CordicGain;
      assign y_in     = '0;
      assign z_in     = s1_item_q.z;
    end else begin : g_next
      assign valid_in = sq_valid_q[k-1];
      assign item_in  = sq_item_q[k-1];
      assign rad_in   = sq_rad_q[k-1];
      assign rem_in   = sq_rem_q[k-1];
      assign root_in  = sq_root_q[k-1];
      assign x_in     = cx_q[k-1];
      assign y_in     = cy_q[k-1];
      assign z_in     = cz_q[k-1];
    end

    assign rem_sh = {rem_in[31:0], rad_in[63:62]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    if (k < TrigSteps) begin : g_cordic
      always_comb begin
        if (z_in >= 0) begin
          x_d = x_in - (y_in >>> k);
          y_d = y_in + (x_in >>> k);
          z_d = z_in - atan_q30(k);
        end else begin
          x_d = x_in + (y_in >>> k);
          y_d = y_in - (x_in >>> k);
          z_d = z_in + atan_q30(k);
        end
      end
    end else begin : g_hold
      assign x_d = x_in;
      assign y_d = y_in;
      assign z_d = z_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_valid_q[k] <= 1'b0;
      end else if (adv) begin
        sq_valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_item_q[k] <= item_in;
        sq_rad_q[k]  <= {rad_in[61:0], 2'b00};
        sq_rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        sq_root_q[k] <= {root_in[30:0], ge};
        cx_q[k]      <= x_d;
        cy_q[k]      <= y_d;
        cz_q[k]      <= z_d;
      end
    end
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    logic               valid_in;
    rva_item_t          item_in;
    logic [2:0][31:0]   rem_in;
    logic [2:0][31:0]   low_in;
    logic [2:0][31:0]   quo_in;
    logic [31:0]        n_in;
    logic signed [33:0] c_in;
    logic signed [33:0] s_in;
    logic [2:0][32:0]   tr;
    logic [2:0]         ge;
    logic [2:0][31:0]   rem_d;
    logic [2:0][31:0]   low_d;
    logic [2:0][31:0]   quo_d;

    if (j == 0) begin : g_first
      assign valid_in = sq_valid_q[SqrtSteps-1];
      assign item_in  = sq_item_q[SqrtSteps-1];
      assign n_in     = sq_root_q[SqrtSteps-1];
      assign c_in     = sq_item_q[SqrtSteps-1].flip ? -cx_q[SqrtSteps-1] : cx_q[SqrtSteps-1];
      assign s_in     = sq_item_q[SqrtSteps-1].flip ? -cy_q[SqrtSteps-1] : cy_q[SqrtSteps-1];
      assign quo_in   = '0;
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = {2'b00, sq_item_q[SqrtSteps-1].mag[i][31:2]};
          low_in[i] = {sq_item_q[SqrtSteps-1].mag[i][1:0], 30'd0};
        end
      end
    end else begin : g_next
      assign valid_in = dv_valid_q[j-1];
      assign item_in  = dv_item_q[j-1];
      assign n_in     = dv_n_q[j-1];
      assign c_in     = dv_c_q[j-1];
      assign s_in     = dv_s_q[j-1];
      assign rem_in   = dv_rem_q[j-1];
      assign low_in   = dv_low_q[j-1];
      assign quo_in   = dv_quo_q[j-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        tr[i]    = {rem_in[i], low_in[i][31]};
        ge[i]    = (tr[i] >= {1'b0, n_in});
        rem_d[i] = ge[i] ? 32'(tr[i] - {1'b0, n_in}) : tr[i][31:0];
        low_d[i] = {low_in[i][30:0], 1'b0};
        quo_d[i] = {quo_in[i][30:0], ge[i]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_valid_q[j] <= 1'b0;
      end else if (adv) begin
        dv_valid_q[j] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_item_q[j] <= item_in;
        dv_rem_q[j]  <= rem_d;
        dv_low_q[j]  <= low_d;
        dv_quo_q[j]  <= quo_d;
        dv_n_q[j]    <= n_in;
        dv_c_q[j]    <= c_in;
        dv_s_q[j]    <= s_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_valid_q <= 1'b0;
      m0_valid_q <= 1'b0;
      m1_valid_q <= 1'b0;
      m2_valid_q <= 1'b0;
      m3_valid_q <= 1'b0;
      m4_valid_q <= 1'b0;
    end else if (adv) begin
      mu_valid_q <= dv_valid_q[DivSteps-1];
      m0_valid_q <= mu_valid_q;
      m1_valid_q <= m0_valid_q;
      m2_valid_q <= m1_valid_q;
      m3_valid_q <= m2_valid_q;
      m4_valid_q <= m3_valid_q;
    end
  end

  logic signed [65:0] uu_rnd [6];
  logic signed [66:0] su_rnd [3];
  logic signed [70:0] p_rnd  [6];
  logic signed [35:0] r_d    [3][3];
  logic signed [39:0] acc_d  [3];

  always_comb begin
    for (int q = 0; q < 6; q++) begin
      uu_rnd[q] = m0_uu_q[q] + 66'sd536870912;
      p_rnd[q]  = m1_p_q[q] + 71'sd536870912;
    end
    for (int k = 0; k < 3; k++) begin
      su_rnd[k] = m0_su_q[k] + 67'sd536870912;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r_d[i][j] = p_rnd[pair_idx(i, j)][65:30];
        if (i == j) begin
          r_d[i][j] = r_d[i][j] + 36'(m1_c_q);
        end else if ((i < j) ? ((i + j) != 2) : ((i + j) == 2)) begin
          r_d[i][j] = r_d[i][j] - m1_t_q[3 - (i + j)];
        end else begin
          r_d[i][j] = r_d[i][j] + m1_t_q[3 - (i + j)];
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      acc_d[i] = '0;
      for (int j = 0; j < 3; j++) begin
        acc_d[i] = acc_d[i] + 40'($signed(m3_pr_q[i][j] + 68'sd536870912) >>> 30);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mu_item_q <= dv_item_q[DivSteps-1];
      for (int i = 0; i < 3; i++) begin
        mu_u_q[i] <= dv_item_q[DivSteps-1].neg[i]
                     ? -$signed({1'b0, dv_quo_q[DivSteps-1][i]})
                     : $signed({1'b0, dv_quo_q[DivSteps-1][i]});
      end
      mu_c_q   <= dv_c_q[DivSteps-1];
      mu_s_q   <= dv_s_q[DivSteps-1];
      mu_omc_q <= OneQ30 - 35'(dv_c_q[DivSteps-1]);

      m0_item_q <= mu_item_q;
      for (int i = 0; i < 3; i++) begin
        for (int j = i; j < 3; j++) begin
          m0_uu_q[pair_idx(i, j)] <= mu_u_q[i] * mu_u_q[j];
        end
        m0_su_q[i] <= mu_s_q * mu_u_q[i];
      end
      m0_c_q   <= mu_c_q;
      m0_omc_q <= mu_omc_q;

      m1_item_q <= m0_item_q;
      for (int q = 0; q < 6; q++) begin
        m1_p_q[q] <= $signed(uu_rnd[q][65:30]) * m0_omc_q;
      end
      for (int k = 0; k < 3; k++) begin
        m1_t_q[k] <= su_rnd[k][65:30];
      end
      m1_c_q <= m0_c_q;

      m2_item_q <= m1_item_q;
      m2_r_q    <= r_d;

      m3_item_q <= m2_item_q;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          m3_pr_q[i][j] <= m2_r_q[i][j] * $signed(m2_item_q.vec[j]);
        end
      end

      m4_item_q <= m3_item_q;
      m4_acc_q  <= acc_d;
    end
  end

  always_comb begin
    ob_d.zero_axis = m4_item_q.zero;
    ob_d.saturated = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (m4_item_q.zero) begin
        ob_d.rot[i] = m4_item_q.vec[i];
      end else if (m4_acc_q[i] > AccMax) begin
        ob_d.rot[i]    = 32'sh7FFFFFFF;
        ob_d.saturated = 1'b1;
      end else if (m4_acc_q[i] < AccMin) begin
        ob_d.rot[i]    = 32'sh80000000;
        ob_d.saturated = 1'b1;
      end else begin
        ob_d.rot[i] = m4_acc_q[i][31:0];
      end
    end
  end

  assign ob_push = m4_valid_q & adv;
  assign ob_pop  = pop & ~empty;
  assign empty   = (ob_cnt_q == 2'd0);
  assign res_o   = ob_mem_q[ob_rd_q];

  always_ff @(posedge clk_i) begin
    if (ob_push) begin
      ob_mem_q[ob_wr_q] <= ob_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_wr_q  <= 1'b0;
      ob_rd_q  <= 1'b0;
      ob_cnt_q <= 2'd0;
    end else begin
      if (ob_push) ob_wr_q <= ~ob_wr_q;
      if (ob_pop) ob_rd_q <= ~ob_rd_q;
      ob_cnt_q <= ob_cnt_q + 2'(ob_push) - 2'(ob_pop);
    end
  end

endmodule
`default_nettype wire

/* rtl/rotate_vector_axis_angle.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Axis-angle vector rotation
// Rotates a Q16.16 vector about an arbitrary axis by a Q4.28 angle.
// ---------------------------------------------------------------------------
// The delay from an accepted word to its result comes mostly from the
// 32-step square root and 32-step division pipelines of the back end.
// One word per cycle unless full is high; one result per cycle on pop.
// Reset clears all valid bits and queue pointers; no result is pending.
module rotate_vector_axis_angle (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic signed [31:0] axis_x_i,
  input  logic signed [31:0] axis_y_i,
  input  logic signed [31:0] axis_z_i,
  input  logic signed [31:0] angle_i,
  output logic              empty,
  input  logic              pop,
  output logic signed [31:0] rot_x_o,
  output logic signed [31:0] rot_y_o,
  output logic signed [31:0] rot_z_o,
  output logic              zero_axis_o,
  output logic              saturated_o
);
  import rva_pkg::*;

  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_empty;
  rva_item_t   f_item;
  rva_item_t   q_item;
  rva_result_t res;

  rva_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .vec_x_i     (vec_x_i),
    .vec_y_i     (vec_y_i),
    .vec_z_i     (vec_z_i),
    .axis_x_i    (axis_x_i),
    .axis_y_i    (axis_y_i),
    .axis_z_i    (axis_z_i),
    .angle_i     (angle_i),
    .item_valid_o(q_push),
    .item_o      (f_item),
    .q_full_i    (q_full)
  );

  rva_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .full_o (q_full),
    .data_i (f_item),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .data_o (q_item)
  );

  rva_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_empty_i(q_empty),
    .q_data_i (q_item),
    .q_pop_o  (q_pop),
    .empty    (empty),
    .pop      (pop),
    .res_o    (res)
  );

  assign rot_x_o     = res.rot[0];
  assign rot_y_o     = res.rot[1];
  assign rot_z_o     = res.rot[2];
  assign zero_axis_o = res.zero_axis;
  assign saturated_o = res.saturated;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && q_full) |-> full)
    else $error("Front end offered a word to a full queue without stalling.");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("Back end took a word from an empty queue.");

  a_zero_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && zero_axis_o) |-> !saturated_o)
    else $error("Zero-axis result flagged as saturated.");

endmodule
`default_nettype wire

/* dv/rotate_vector_axis_angle_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Axis-angle rotation checker
// Watches the input and result queues of the rotator, predicts every rotated
// word in fixed point and compares each popped word with the oldest one due.
// ---------------------------------------------------------------------------
module rotate_vector_axis_angle_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  input  logic           full,
  input  rva_pkg::word_t vec_x_i,
  input  rva_pkg::word_t vec_y_i,
  input  rva_pkg::word_t vec_z_i,
  input  rva_pkg::word_t axis_x_i,
  input  rva_pkg::word_t axis_y_i,
  input  rva_pkg::word_t axis_z_i,
  input  rva_pkg::word_t angle_i,
  input  logic           empty,
  input  logic           pop,
  input  rva_pkg::word_t rot_x_i,
  input  rva_pkg::word_t rot_y_i,
  input  rva_pkg::word_t rot_z_i,
  input  logic           zero_axis_i,
  input  logic           saturated_i,
  output int             mismatch_cnt_o,
  output int             due_cnt_o
);
  import rva_pkg::*;

  localparam longint PiQ = 843314857;
  localparam longint TwoPiQ = 1686629713;
  localparam longint HalfPiQ = 421657428;
  localparam longint GainQ = 652032874;
  localparam longint OneQ = 1073741824;

  localparam longint ArcTanQ30 [30] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
    127, 63, 31, 15, 8, 4, 2
  };

  typedef struct {
    word_t x;
    word_t y;
    word_t z;
    logic  zero_axis;
    logic  saturated;
  } rotation_t;

  rotation_t rot_due_q[$];

  function automatic longint rnd30(longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void sine_cosine(longint a, output longint sn, output longint cs);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    bit flip;
    x = GainQ;
    y = 0;
    flip = 0;
    for (int k = 0; k < 2; k++) begin
      if (a >= PiQ) a -= TwoPiQ;
      else if (a < -PiQ) a += TwoPiQ;
    end
    if (a > HalfPiQ) begin
      a -= PiQ;
      flip = 1;
    end else if (a < -HalfPiQ) begin
      a += PiQ;
      flip = 1;
    end
    z = a * 4;
    for (int k = 0; k < TrigSteps; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ArcTanQ30[k];
      end else begin
        x += dx;
        y -= dy;
        z += ArcTanQ30[k];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cs = x;
    sn = y;
  endfunction

  function automatic rotation_t rotate_word(word_t vx, word_t vy, word_t vz,
                                            word_t ux, word_t uy, word_t uz, word_t ang);
    rotation_t res;
    longint v[3];
    longint ax[3];
    longint u[3];
    longint r[3][3];
    longint sn;
    longint cs;
    longint omc;
    longint maxm;
    longint m;
    longint e;
    longint t;
    longint acc;
    longint unsigned sumsq;
    longint unsigned n;
    longint unsigned um;
    word_t outv[3];
    v[0] = vx; v[1] = vy; v[2] = vz;
    ax[0] = ux; ax[1] = uy; ax[2] = uz;
    res.zero_axis = 0;
    res.saturated = 0;
    if (ux == 0 && uy == 0 && uz == 0) begin
      res.x = vx;
      res.y = vy;
      res.z = vz;
      res.zero_axis = 1;
      return res;
    end
    maxm = 0;
    for (int i = 0; i < 3; i++) begin
      m = ax[i] < 0 ? -ax[i] : ax[i];
      if (m > maxm) maxm = m;
    end
    for (int i = 0; i < 31 && maxm < (64'sd1 <<< 30); i++) begin
      maxm *= 2;
      for (int j = 0; j < 3; j++) ax[j] *= 2;
    end
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      um = ax[i] < 0 ? -ax[i] : ax[i];
      sumsq += um * um;
    end
    n = int_sqrt(sumsq);
    for (int i = 0; i < 3; i++) begin
      um = ax[i] < 0 ? -ax[i] : ax[i];
      m = longint'((um << 30) / n);
      u[i] = ax[i] < 0 ? -m : m;
    end
    sine_cosine(longint'(ang), sn, cs);
    omc = OneQ - cs;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        e = rnd30(rnd30(u[i] * u[j]) * omc);
        if (i == j) begin
          e += cs;
        end else begin
          t = rnd30(sn * u[3 - (i + j)]);
          if ((i < j) ? ((i + j) != 2) : ((i + j) == 2)) e -= t;
          else e += t;
        end
        r[i][j] = e;
      end
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += rnd30(r[i][j] * v[j]);
      if (acc > 64'sd2147483647) begin
        acc = 64'sd2147483647;
        res.saturated = 1;
      end else if (acc < -64'sd2147483648) begin
        acc = -64'sd2147483648;
        res.saturated = 1;
      end
      outv[i] = acc[31:0];
    end
    res.x = outv[0];
    res.y = outv[1];
    res.z = outv[2];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rotation_t want;
    if (!rst_ni) begin
      rot_due_q.delete();
      mismatch_cnt_o <= 0;
    end else begin
      if (push && !full) begin
        rot_due_q.push_back(rotate_word(vec_x_i, vec_y_i, vec_z_i,
                                        axis_x_i, axis_y_i, axis_z_i, angle_i));
      end
      if (pop && !empty) begin
        if (rot_due_q.size() == 0) begin
          if (mismatch_cnt_o < 10) $display("%t: word popped with none due", $realtime);
          mismatch_cnt_o <= mismatch_cnt_o + 1;
        end else begin
          want = rot_due_q.pop_front();
          if (rot_x_i !== want.x || rot_y_i !== want.y || rot_z_i !== want.z ||
              zero_axis_i !== want.zero_axis || saturated_i !== want.saturated) begin
            if (mismatch_cnt_o < 10) begin
              $display("%t: expected rot %0d %0d %0d zero %b sat %b", $realtime,
                       want.x, want.y, want.z, want.zero_axis, want.saturated);
              $display("%t: actual   rot %0d %0d %0d zero %b sat %b", $realtime,
                       rot_x_i, rot_y_i, rot_z_i, zero_axis_i, saturated_i);
            end
            mismatch_cnt_o <= mismatch_cnt_o + 1;
          end
        end
      end
    end
    due_cnt_o = rot_due_q.size();
  end

endmodule

/* dv/rotate_vector_axis_angle_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Axis-angle rotation testbench
// Pushes directed and random rotation words with random gaps, pops results
// with random stalls and one long hold-off, and reports the checker verdict.
// ---------------------------------------------------------------------------
module rotate_vector_axis_angle_tb;
  import rva_pkg::*;

  localparam int NumRandom = 1620;
  localparam int QuietFrom = 1450;
  localparam int IdleLimit = 5000;

  logic  clk_i = 0;
  logic  rst_ni = 0;
  logic  push = 0;
  logic  pop = 0;
  logic  full;
  logic  empty;
  word_t vec_x = 0, vec_y = 0, vec_z = 0;
  word_t axis_x = 0, axis_y = 0, axis_z = 0, angle = 0;
  word_t rot_x, rot_y, rot_z;
  logic  zero_axis, saturated;
  int    mismatch_cnt;
  int    due_cnt;
  int    words_sent = 0;
  bit    quiet = 0;
  bit    hold_done = 0;
  int    idle_cycles = 0;

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  rotate_vector_axis_angle dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .vec_x_i(vec_x), .vec_y_i(vec_y), .vec_z_i(vec_z),
    .axis_x_i(axis_x), .axis_y_i(axis_y), .axis_z_i(axis_z), .angle_i(angle),
    .empty(empty), .pop(pop),
    .rot_x_o(rot_x), .rot_y_o(rot_y), .rot_z_o(rot_z),
    .zero_axis_o(zero_axis), .saturated_o(saturated)
  );

  rotate_vector_axis_angle_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .vec_x_i(vec_x), .vec_y_i(vec_y), .vec_z_i(vec_z),
    .axis_x_i(axis_x), .axis_y_i(axis_y), .axis_z_i(axis_z), .angle_i(angle),
    .empty(empty), .pop(pop),
    .rot_x_i(rot_x), .rot_y_i(rot_y), .rot_z_i(rot_z),
    .zero_axis_i(zero_axis), .saturated_i(saturated),
    .mismatch_cnt_o(mismatch_cnt), .due_cnt_o(due_cnt)
  );

  task automatic send_word(word_t vx, word_t vy, word_t vz,
                           word_t ux, word_t uy, word_t uz, word_t ang);
    @(negedge clk_i);
    vec_x = vx; vec_y = vy; vec_z = vz;
    axis_x = ux; axis_y = uy; axis_z = uz; angle = ang;
    push = 1;
    do @(posedge clk_i); while (full);
    words_sent++;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      @(negedge clk_i);
      push = 0;
      repeat ($urandom_range(1, 14) - 1) @(negedge clk_i);
    end
  endtask

  function automatic word_t rand_field();
    word_t w;
    w = $urandom;
    case ($urandom_range(0, 3))
      0: return w;
      1: return w >>> $urandom_range(0, 31);
      2: return w >>> $urandom_range(12, 20);
      default: return $urandom_range(0, 3) == 0 ? 0 : w >>> $urandom_range(20, 31);
    endcase
  endfunction

  function automatic word_t rand_angle();
    word_t w;
    w = $urandom;
    case ($urandom_range(0, 2))
      0: return w;
      1: return w >>> 2;
      default: return 843314857 - 4 + $urandom_range(0, 8) - (w[0] ? 1686629713 : 0);
    endcase
  endfunction

  initial begin
    word_t vx, vy, vz, ux, uy, uz;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    send_word(32'h7fffffff, 32'h80000000, 32'h00010000, 0, 0, 0, 32'h12345678);
    send_word(32'h80000000, 32'h7fffffff, 32'hffffffff, 0, 0, 0, 32'h80000000);
    send_word(32'h00010000, 0, 0, 0, 0, 32'h00010000, 421657428);
    send_word(32'h00010000, 0, 0, 0, 0, 32'h00010000, 421657429);
    send_word(32'h00010000, 0, 0, 0, 0, 32'h00010000, -421657428);
    send_word(32'h00010000, 0, 0, 0, 0, 32'h00010000, -421657429);
    send_word(32'h00010000, 32'h00020000, 0, 0, 0, 1, 843314857);
    send_word(32'h00010000, 32'h00020000, 0, 0, 0, -1, -843314857);
    send_word(32'h00010000, 32'h00020000, 0, 0, 0, -1, -843314858);
    send_word(32'h00010000, 32'h00030000, 32'h00050000, 1, 1, 1, 0);
    send_word(32'h00010000, 32'h00030000, 32'h00050000, 32'h80000000, 0, 0, 32'h7fffffff);
    send_word(32'h00010000, 32'h00030000, 32'h00050000, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h80000000);
    send_word(32'h00010000, 32'h00030000, 32'h00050000, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 1686629713);
    send_word(32'h7fffffff, 32'h7fffffff, 0, 0, 0, 32'h00010000, 210828714);
    send_word(32'h80000000, 32'h80000000, 0, 0, 0, 32'h00010000, 210828714);
    send_word(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, 32'h80000000,
              -210828714);
    send_word(32'h80000000, 32'h80000000, 32'h80000000, 32'hffffffff, 32'h00000001,
              32'h7fffffff, 32'h40000000);

    for (int i = 0; i < NumRandom; i++) begin
      if (i >= QuietFrom) quiet = 1;
      vx = rand_field(); vy = rand_field(); vz = rand_field();
      ux = rand_field(); uy = rand_field(); uz = rand_field();
      if ($urandom_range(0, 29) == 0) begin
        ux = 0; uy = 0; uz = 0;
      end
      send_word(vx, vy, vz, ux, uy, uz, rand_angle());
    end
    @(negedge clk_i);
    push = 0;
    wait (due_cnt == 0 && hold_done);
    repeat (150) @(posedge clk_i);
    if (mismatch_cnt == 0 && due_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && words_sent >= 300) begin
        pop = 0;
        repeat (400) @(negedge clk_i);
        hold_done = 1;
      end
      if (!quiet && $urandom_range(0, 9) == 0) begin
        pop = 0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk_i);
      end else begin
        pop = 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

/* rotate_vector_axis_angle.f */
rtl/rva_pkg.sv
rtl/rva_front.sv
rtl/rva_queue.sv
rtl/rva_back.sv
rtl/rotate_vector_axis_angle.sv
dv/rotate_vector_axis_angle_checker.sv
dv/rotate_vector_axis_angle_tb.sv
